// ===== hdl/tcq_pkg.sv =====
package tcq_pkg;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

    localparam logic [2:0] SOS_LEVEL_RESET = 3'd3;

    typedef struct packed {
        logic [31:0] msg_id;
        logic [15:0] sender;
        logic [15:0] dest;
        logic [7:0]  payload_ref;
        logic [2:0]  prio;
        logic [7:0]  hop_limit;
        logic [15:0] backoff;
        logic [31:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        action_t     action;
        logic [31:0] msg_id;
        logic [15:0] src_id;
        logic [15:0] dest_id;
        logic [7:0]  payload_ref;
        logic [2:0]  priority_level;
        logic [15:0] backoff_ms;
        logic [7:0]  hop_limit;
        logic [31:0] now_ms;
    } item_t;

endpackage

// ===== hdl/tcq_ram.sv =====
module tcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/two_class_tx_queue_with_backoff.sv =====
// Two-class transmit queue: an emergency ring (SOS_DEPTH entries) and a normal
// ring (NORMAL_DEPTH entries) of message descriptors. An enqueue whose priority
// equals the programmed sos_level goes to the emergency ring, which drops its
// oldest entry when full and flags dropped_oldest; other messages go to the
// normal ring, which rejects them (ok low) when full. A dequeue returns the
// emergency head if its backoff has elapsed, else the normal head if its
// backoff has elapsed, else ok low. Every item yields exactly one result.
// An item is taken into an input register, processed there and moved to the
// result register; with no output stall one item is accepted per clock. Each
// ring sits in a RAM whose registered read port is kept aimed at the ring head.
module two_class_tx_queue_with_backoff
    import tcq_pkg::*;
#(
    parameter int SOS_DEPTH    = 8,
    parameter int NORMAL_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [31:0]                       msg_id,
    input  logic [15:0]                       src_id,
    input  logic [15:0]                       dest_id,
    input  logic [7:0]                        payload_ref,
    input  logic [2:0]                        priority_level,
    input  logic [15:0]                       backoff_ms,
    input  logic [7:0]                        hop_limit,
    input  logic [31:0]                       now_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ok,
    output logic [31:0]                       out_msg_id,
    output logic [15:0]                       out_sender,
    output logic [15:0]                       out_dest,
    output logic [7:0]                        out_payload_ref,
    output logic [2:0]                        out_priority,
    output logic [7:0]                        out_hop_limit,
    output logic [15:0]                       out_backoff,
    output logic [31:0]                       out_enqueue_time,
    output logic                              dropped_oldest,
    output logic [$clog2(SOS_DEPTH+1)-1:0]    sos_count,
    output logic [$clog2(NORMAL_DEPTH+1)-1:0] normal_count
);

    localparam int SAW = $clog2(SOS_DEPTH);
    localparam int SCW = $clog2(SOS_DEPTH + 1);
    localparam int NAW = $clog2(NORMAL_DEPTH);
    localparam int NCW = $clog2(NORMAL_DEPTH + 1);

    logic [2:0]     sos_level_reg;

    logic           s1_valid_reg;
    item_t          s1_item_reg;
    logic           fire;

    logic [SAW-1:0] sos_head_reg, sos_head_next;
    logic [SAW-1:0] sos_tail_reg, sos_tail_next;
    logic [SCW-1:0] sos_fill_reg, sos_fill_next;
    logic [NAW-1:0] norm_head_reg, norm_head_next;
    logic [NAW-1:0] norm_tail_reg, norm_tail_next;
    logic [NCW-1:0] norm_fill_reg, norm_fill_next;

    logic           sos_we, norm_we;
    logic [SAW-1:0] sos_rd_addr;
    logic [NAW-1:0] norm_rd_addr;
    logic [ENTRY_W-1:0] sos_rd_data, norm_rd_data;
    logic           sos_fwd_reg, sos_fwd_next;
    logic           norm_fwd_reg, norm_fwd_next;
    entry_t         sos_fwd_data_reg, norm_fwd_data_reg;
    entry_t         sos_head_entry, norm_head_entry;
    entry_t         new_entry;

    logic           sos_ready, norm_ready;
    logic           res_ok;
    logic           res_drop;
    entry_t         res_entry;

    logic           out_valid_reg;
    logic           ok_reg;
    entry_t         out_entry_reg;
    logic           drop_reg;
    logic [SCW-1:0] sos_count_reg;
    logic [NCW-1:0] norm_count_reg;

    assign fire     = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sos_level_reg <= SOS_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            sos_level_reg <= cfg_wr_data;
        end
    end

    assign new_entry = '{
        msg_id:      s1_item_reg.msg_id,
        sender:      s1_item_reg.src_id,
        dest:        s1_item_reg.dest_id,
        payload_ref: s1_item_reg.payload_ref,
        prio:        s1_item_reg.priority_level,
        hop_limit:   s1_item_reg.hop_limit,
        backoff:     s1_item_reg.backoff_ms,
        stamp:       s1_item_reg.now_ms
    };

    assign sos_head_entry  = sos_fwd_reg  ? sos_fwd_data_reg  : entry_t'(sos_rd_data);
    assign norm_head_entry = norm_fwd_reg ? norm_fwd_data_reg : entry_t'(norm_rd_data);

    assign sos_ready  = (sos_fill_reg != '0)
                     && ((s1_item_reg.now_ms - sos_head_entry.stamp)
                         >= {16'd0, sos_head_entry.backoff});
    assign norm_ready = (norm_fill_reg != '0)
                     && ((s1_item_reg.now_ms - norm_head_entry.stamp)
                         >= {16'd0, norm_head_entry.backoff});

    function automatic logic [SAW-1:0] sos_bump(input logic [SAW-1:0] p);
        return (p == SAW'(SOS_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [NAW-1:0] norm_bump(input logic [NAW-1:0] p);
        return (p == NAW'(NORMAL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        sos_head_next  = sos_head_reg;
        sos_tail_next  = sos_tail_reg;
        sos_fill_next  = sos_fill_reg;
        norm_head_next = norm_head_reg;
        norm_tail_next = norm_tail_reg;
        norm_fill_next = norm_fill_reg;
        sos_we         = 1'b0;
        norm_we        = 1'b0;
        res_ok         = 1'b0;
        res_drop       = 1'b0;
        res_entry      = '0;
        unique case (s1_item_reg.action)
            ACT_ENQUEUE:
            begin
                if (s1_item_reg.priority_level == sos_level_reg)
                begin
                    sos_we        = 1'b1;
                    sos_tail_next = sos_bump(sos_tail_reg);
                    res_ok        = 1'b1;
                    if (sos_fill_reg == SCW'(SOS_DEPTH))
                    begin
                        sos_head_next = sos_bump(sos_head_reg);
                        res_drop      = 1'b1;
                    end
                    else
                    begin
                        sos_fill_next = sos_fill_reg + 1'b1;
                    end
                end
                else if (norm_fill_reg != NCW'(NORMAL_DEPTH))
                begin
                    norm_we        = 1'b1;
                    norm_tail_next = norm_bump(norm_tail_reg);
                    norm_fill_next = norm_fill_reg + 1'b1;
                    res_ok         = 1'b1;
                end
            end
            ACT_DEQUEUE:
            begin
                priority if (sos_ready)
                begin
                    sos_head_next = sos_bump(sos_head_reg);
                    sos_fill_next = sos_fill_reg - 1'b1;
                    res_ok        = 1'b1;
                    res_entry     = sos_head_entry;
                end
                else if (norm_ready)
                begin
                    norm_head_next = norm_bump(norm_head_reg);
                    norm_fill_next = norm_fill_reg - 1'b1;
                    res_ok         = 1'b1;
                    res_entry      = norm_head_entry;
                end
            end
            default:
            begin
            end
        endcase
    end

    // read port tracks the head; bypass a write landing on the head slot
    assign sos_rd_addr   = fire ? sos_head_next  : sos_head_reg;
    assign norm_rd_addr  = fire ? norm_head_next : norm_head_reg;
    assign sos_fwd_next  = fire && sos_we  && (sos_tail_reg  == sos_rd_addr);
    assign norm_fwd_next = fire && norm_we && (norm_tail_reg == norm_rd_addr);

    tcq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SOS_DEPTH)
    ) u_sos_ram (
        .clk     (clk),
        .wr_en   (fire && sos_we),
        .wr_addr (sos_tail_reg),
        .wr_data (new_entry),
        .rd_addr (sos_rd_addr),
        .rd_data (sos_rd_data)
    );

    tcq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NORMAL_DEPTH)
    ) u_norm_ram (
        .clk     (clk),
        .wr_en   (fire && norm_we),
        .wr_addr (norm_tail_reg),
        .wr_data (new_entry),
        .rd_addr (norm_rd_addr),
        .rd_data (norm_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sos_head_reg  <= '0;
            sos_tail_reg  <= '0;
            sos_fill_reg  <= '0;
            norm_head_reg <= '0;
            norm_tail_reg <= '0;
            norm_fill_reg <= '0;
            sos_fwd_reg   <= 1'b0;
            norm_fwd_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                sos_head_reg  <= sos_head_next;
                sos_tail_reg  <= sos_tail_next;
                sos_fill_reg  <= sos_fill_next;
                norm_head_reg <= norm_head_next;
                norm_tail_reg <= norm_tail_next;
                norm_fill_reg <= norm_fill_next;
            end
            sos_fwd_reg  <= sos_fwd_next;
            norm_fwd_reg <= norm_fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= '{
                action:         action_t'(action),
                msg_id:         msg_id,
                src_id:         src_id,
                dest_id:        dest_id,
                payload_ref:    payload_ref,
                priority_level: priority_level,
                backoff_ms:     backoff_ms,
                hop_limit:      hop_limit,
                now_ms:         now_ms
            };
        end
        if (sos_fwd_next)
        begin
            sos_fwd_data_reg <= new_entry;
        end
        if (norm_fwd_next)
        begin
            norm_fwd_data_reg <= new_entry;
        end
        if (fire)
        begin
            ok_reg         <= res_ok;
            out_entry_reg  <= res_entry;
            drop_reg       <= res_drop;
            sos_count_reg  <= sos_fill_next;
            norm_count_reg <= norm_fill_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ok               = ok_reg;
    assign out_msg_id       = out_entry_reg.msg_id;
    assign out_sender       = out_entry_reg.sender;
    assign out_dest         = out_entry_reg.dest;
    assign out_payload_ref  = out_entry_reg.payload_ref;
    assign out_priority     = out_entry_reg.prio;
    assign out_hop_limit    = out_entry_reg.hop_limit;
    assign out_backoff      = out_entry_reg.backoff;
    assign out_enqueue_time = out_entry_reg.stamp;
    assign dropped_oldest   = drop_reg;
    assign sos_count        = sos_count_reg;
    assign normal_count     = norm_count_reg;

endmodule
